[hdl/stepper_position_stepper_macros.svh]
// assertion helpers shared by the stepper rtl
`ifndef STEPPER_POSITION_STEPPER_MACROS_SVH
`define STEPPER_POSITION_STEPPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sps_pkg.sv]
package sps_pkg;

  localparam int unsigned STEPS_PER_POSITION = 40;
  localparam int unsigned IDX_W = 7;
  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(2 * STEPS_PER_POSITION - 1);

  localparam int unsigned SPEED_MIN   = 10;
  localparam int unsigned SPEED_MAX   = 150;
  localparam int unsigned SPEED_RESET = 60;
  localparam int unsigned HALF_NUM    = 18750;

  localparam logic [10:0] HALF_RESET   = 11'(HALF_NUM / SPEED_RESET);
  localparam logic signed [10:0] MIN_POS_RESET = -11'sd10;
  localparam logic signed [10:0] MAX_POS_RESET = 11'sd50;
  localparam logic signed [11:0] TARGET_SENTINEL = 12'sd1000;

  typedef enum logic [1:0] {
    CFG_MIN_POS = 2'd0,
    CFG_MAX_POS = 2'd1,
    CFG_SPEED   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               action;
    logic signed [11:0] new_target;
  } sps_in_t;

  typedef struct packed {
    logic               step_level;
    logic               direction;
    logic signed [10:0] position;
    logic signed [10:0] target;
    logic               at_target;
    logic               moving;
  } sps_out_t;

  typedef logic [10:0] half_tbl_t [256];

  // half period in ticks for every raw speed write, saturated to the legal range
  function automatic half_tbl_t build_half_tbl();
    half_tbl_t   tbl;
    int unsigned s;
    int unsigned q;
    for (int v = 0; v < 256; v++) begin
      if (v < SPEED_MIN) s = SPEED_MIN;
      else if (v > SPEED_MAX) s = SPEED_MAX;
      else s = v;
      q = 0;
      for (int b = 10; b >= 0; b--) begin
        if (((q | (1 << b)) * s) <= HALF_NUM) q = q | (1 << b);
      end
      tbl[v] = q[10:0];
    end
    return tbl;
  endfunction

  localparam half_tbl_t HALF_TBL = build_half_tbl();

endpackage

[hdl/stepper_position_stepper.sv]
// a result is registered in the output register, or in the skid register on a stall
// throughput: one item per cycle until the skid fills; an output and a skid register
// keep the input open while a finished result waits
// reset: position, target and move state clear, limits -10 and 50, speed 60
// (half period 312 ticks); config writes apply to items that transfer after the write
`include "stepper_position_stepper_macros.svh"

module stepper_position_stepper (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sps_pkg::sps_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sps_pkg::sps_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [10:0]      cfg_data_i
);

  logic signed [10:0] min_pos_q, max_pos_q;
  logic [10:0]        half_q;

  logic signed [10:0] cur_pos_q, cur_pos_d;
  logic signed [10:0] tgt_pos_q, tgt_pos_d;
  logic               move_active_q, move_active_d;
  logic               move_dir_q, move_dir_d;
  logic [sps_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [10:0]        tmr_q, tmr_d;

  sps_pkg::sps_out_t  res;
  sps_pkg::sps_out_t  out_q, skid_q;
  logic               out_valid_q, skid_valid_q;

  logic               in_acc, out_pop;

  logic signed [11:0] t_in, min_ext, max_ext, t_lo;
  logic [11:0]        tmr_inc, tmr_end;
  logic [sps_pkg::IDX_W-1:0] idx_adv;
  logic [10:0]        tmr_adv;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_pop     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pos_q <= sps_pkg::MIN_POS_RESET;
      max_pos_q <= sps_pkg::MAX_POS_RESET;
      half_q    <= sps_pkg::HALF_RESET;
    end else if (cfg_valid_i) begin
      unique case (sps_pkg::cfg_idx_e'(cfg_index_i))
        sps_pkg::CFG_MIN_POS: min_pos_q <= cfg_data_i;
        sps_pkg::CFG_MAX_POS: max_pos_q <= cfg_data_i;
        sps_pkg::CFG_SPEED:   half_q    <= sps_pkg::HALF_TBL[cfg_data_i[7:0]];
        default: ;
      endcase
    end
  end

  // target clamp, sentinels pass through
  assign t_in    = in_data_i.new_target;
  assign min_ext = 12'(min_pos_q);
  assign max_ext = 12'(max_pos_q);
  always_comb begin
    t_lo = (t_in > max_ext) ? max_ext : t_in;
    t_lo = (t_lo < min_ext) ? min_ext : t_lo;
    if (t_in == sps_pkg::TARGET_SENTINEL || t_in == -sps_pkg::TARGET_SENTINEL) begin
      t_lo = t_in;
    end
  end

  // half period advance
  always_comb begin
    tmr_inc = {1'b0, tmr_q} + 12'd1;
    if (tmr_inc >= {1'b0, half_q}) begin
      tmr_adv = '0;
      idx_adv = idx_q + sps_pkg::IDX_W'(1);
    end else begin
      tmr_adv = tmr_inc[10:0];
      idx_adv = idx_q;
    end
    tmr_end = {1'b0, tmr_adv} + 12'd1;
  end

  always_comb begin
    cur_pos_d     = cur_pos_q;
    tgt_pos_d     = tgt_pos_q;
    move_active_d = move_active_q;
    move_dir_d    = move_dir_q;
    idx_d         = idx_q;
    tmr_d         = tmr_q;
    if (in_data_i.action) begin
      tgt_pos_d = t_lo[10:0];
    end else if (!move_active_q) begin
      if (tgt_pos_q != cur_pos_q) begin
        move_dir_d    = tgt_pos_q > cur_pos_q;
        move_active_d = 1'b1;
        idx_d         = '0;
        tmr_d         = '0;
      end
    end else begin
      idx_d = idx_adv;
      tmr_d = tmr_adv;
      // last tick of the move steps the position
      if (idx_adv >= sps_pkg::LAST_INDEX && tmr_end >= {1'b0, half_q}) begin
        cur_pos_d     = move_dir_q ? cur_pos_q + 11'sd1 : cur_pos_q - 11'sd1;
        move_active_d = 1'b0;
        idx_d         = '0;
        tmr_d         = '0;
      end
    end
  end

  always_comb begin
    res.step_level = move_active_d && !idx_d[0];
    res.direction  = move_dir_d;
    res.position   = cur_pos_d;
    res.target     = tgt_pos_d;
    res.at_target  = !move_active_d && (cur_pos_d == tgt_pos_d);
    res.moving     = move_active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pos_q     <= '0;
      tgt_pos_q     <= '0;
      move_active_q <= 1'b0;
      move_dir_q    <= 1'b0;
      idx_q         <= '0;
      tmr_q         <= '0;
    end else if (in_acc) begin
      cur_pos_q     <= cur_pos_d;
      tgt_pos_q     <= tgt_pos_d;
      move_active_q <= move_active_d;
      move_dir_q    <= move_dir_d;
      idx_q         <= idx_d;
      tmr_q         <= tmr_d;
    end
  end

  // output register with skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) out_q <= skid_q;
    end else if (in_acc) begin
      if (out_valid_q && !out_pop) skid_q <= res;
      else out_q <= res;
    end
  end

  `SPS_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q,
                   "skid register holds a result while the output register is empty")
  `SPS_ASSERT_IMPL(a_skid_fill_on_stall, $rose(skid_valid_q),
                   $past(out_valid_q) && $past(out_stall_i),
                   "skid register filled without a stalled output")
  `SPS_ASSERT_IMPL(a_idle_counters_clear, !move_active_q, idx_q == '0 && tmr_q == '0,
                   "move counters not cleared while idle")
  `SPS_ASSERT_IMPL(a_pos_only_at_move_end, cur_pos_q != $past(cur_pos_q),
                   $past(move_active_q) && !move_active_q,
                   "position changed outside the end of a move")
  `SPS_ASSERT_NEXT(a_write_keeps_move, in_acc && in_data_i.action,
                   move_active_q == $past(move_active_q) && idx_q == $past(idx_q),
                   "target transfer disturbed the move in progress")

endmodule
